/* hdl/text_console_cursor_grid_macros.svh */
// Assertion shorthands for the console cursor grid.
// Every property samples on clock and is off while reset is high.
`ifndef TEXT_CONSOLE_CURSOR_GRID_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_GRID_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define TCG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TCG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/tcg_pkg.sv */
package tcg_pkg;

   // default grid limits
   localparam int DEF_MAX_COLUMNS = 160;
   localparam int DEF_MAX_ROWS    = 64;

   // field widths
   localparam int CODE_W     = 21;
   localparam int SLOT_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int CFG_COLS_W = 8;
   localparam int CFG_ROWS_W = 7;
   localparam int OUT_ROW_W  = 6;
   localparam int OUT_COL_W  = 8;
   localparam int OUT_IDX_W  = 14;
   localparam int CELL_W     = 16;
   localparam int SCROLL_W   = 64;

   // control characters
   localparam logic [CODE_W-1:0] CH_NEWLINE   = 21'd10;
   localparam logic [CODE_W-1:0] CH_RETURN    = 21'd13;
   localparam logic [CODE_W-1:0] CH_BACKSPACE = 21'd8;
   localparam logic [CODE_W-1:0] CH_TAB       = 21'd9;
   localparam int                TAB_STOP     = 8;

   localparam logic [SLOT_W-1:0] BLANK_CHAR  = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h07;
   localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, BLANK_CHAR};

   localparam logic [CFG_COLS_W-1:0] RESET_COLUMNS = 8'd80;
   localparam logic [CFG_ROWS_W-1:0] RESET_ROWS    = 7'd25;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ATTRIBUTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS      = 2'd2;

   typedef struct packed {
      logic [CODE_W-1:0] code_point;
      logic [SLOT_W-1:0] glyph_slot;
   } req_type;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] cursor_row;
      logic [OUT_COL_W-1:0] cursor_col;
      logic                 cell_written;
      logic [OUT_IDX_W-1:0] cell_index;
      logic [CELL_W-1:0]    cell_value;
      logic                 scrolled;
      logic [SCROLL_W-1:0]  scroll_total;
   } rsp_type;

   typedef struct packed {
      logic clear_step;
      logic take;
      logic exec;
      logic scroll_prime;
      logic scroll_step;
      logic publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scroll_need;
      logic scroll_last;
   } ctrl_status_type;

endpackage

/* hdl/tcg_ctrl.sv */
module tcg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  tcg_pkg::ctrl_status_type  status,
   output tcg_pkg::ctrl_cmd_type     cmd
);
   import tcg_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_PRIME  = 3'd3;
   localparam logic [2:0] ST_SCROLL = 3'd4;
   localparam logic [2:0] ST_HOLD   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.scroll_need ? ST_PRIME : ST_HOLD;
         end
         ST_PRIME: begin
            cmd.scroll_prime = 1'b1;
            state_in         = ST_SCROLL;
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (status.scroll_last) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            // publish, and take the next word in the same cycle
            if (rsp_free) begin
               cmd.publish = 1'b1;
               req_ready   = 1'b1;
               if (req_valid) begin
                  cmd.take = 1'b1;
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      if (cmd.publish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/tcg_datapath.sv */
module tcg_datapath #(
   parameter int MAX_COLUMNS = tcg_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = tcg_pkg::DEF_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [tcg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcg_pkg::CSR_DATA_W-1:0]   csr_data,
   input  tcg_pkg::req_type                 req_data,
   output tcg_pkg::rsp_type                 rsp_data,
   input  tcg_pkg::ctrl_cmd_type            cmd,
   output tcg_pkg::ctrl_status_type         status
);
   import tcg_pkg::*;

   localparam int CELLS  = MAX_ROWS * MAX_COLUMNS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int RA_W   = CNT_W + 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ECOL_W = $clog2(MAX_COLUMNS + 1);
   localparam int EROW_W = $clog2(MAX_ROWS + 1);
   localparam int SUM_W  = ECOL_W + 4;
   localparam int PROD_W = ROW_W + ECOL_W;
   localparam int TOT_W  = EROW_W + ECOL_W;

   // configuration
   logic [ATTR_W-1:0]     attr_ff;
   logic [CFG_COLS_W-1:0] cols_cfg_ff;
   logic [CFG_ROWS_W-1:0] rows_cfg_ff;
   logic [ECOL_W-1:0]     eff_cols;
   logic [EROW_W-1:0]     eff_rows;

   // cursor and item
   logic [ROW_W-1:0]    row_ff, row_next;
   logic [COL_W-1:0]    col_ff;
   logic [SUM_W-1:0]    col_sum;
   logic [CODE_W-1:0]   cp_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic                printable, wrap_chk, row_step, scroll_need;
   logic [PROD_W-1:0]   prod;
   logic [ADDR_W-1:0]   cell_addr;
   logic [CELL_W-1:0]   cell_val, blank_val;
   logic [SCROLL_W-1:0] scroll_cnt_ff;
   logic [CNT_W-1:0]    total_ff;
   logic [TOT_W-1:0]    total_prod;
   rsp_type             res_ff, rsp_ff;

   // grid store and sweep
   logic [CELL_W-1:0] grid_mem [0:CELLS-1];
   logic [CELL_W-1:0] rd_data_ff;
   logic              rd_ok_ff, rd_ok_in;
   logic [CNT_W-1:0]  sweep_ff, sweep_in;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [RA_W-1:0]   ra_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff     <= RESET_ATTR;
         cols_cfg_ff <= RESET_COLUMNS;
         rows_cfg_ff <= RESET_ROWS;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TEXT_ATTRIBUTE: attr_ff     <= csr_data;
            CSR_GRID_COLUMNS:   cols_cfg_ff <= csr_data;
            CSR_GRID_ROWS:      rows_cfg_ff <= csr_data[CFG_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp geometry into 1..max
   always_comb begin
      if (cols_cfg_ff == '0) eff_cols = ECOL_W'(1);
      else if (32'(cols_cfg_ff) > MAX_COLUMNS) eff_cols = ECOL_W'(MAX_COLUMNS);
      else eff_cols = ECOL_W'(cols_cfg_ff);
      if (rows_cfg_ff == '0) eff_rows = EROW_W'(1);
      else if (32'(rows_cfg_ff) > MAX_ROWS) eff_rows = EROW_W'(MAX_ROWS);
      else eff_rows = EROW_W'(rows_cfg_ff);
   end

   assign blank_val  = {attr_ff, BLANK_CHAR};
   assign cell_val   = {attr_ff, slot_ff};
   assign prod       = PROD_W'(row_ff) * PROD_W'(eff_cols);
   assign cell_addr  = ADDR_W'(prod + PROD_W'(col_ff));
   assign total_prod = TOT_W'(eff_rows) * TOT_W'(eff_cols);

   // cursor move for the held word
   always_comb begin
      row_next  = row_ff;
      col_sum   = SUM_W'(col_ff);
      printable = 1'b0;
      wrap_chk  = 1'b0;
      row_step  = 1'b0;
      if (cp_ff == CH_NEWLINE) begin
         col_sum  = '0;
         row_step = 1'b1;
      end else if (cp_ff == CH_RETURN) begin
         col_sum = '0;
      end else if (cp_ff == CH_BACKSPACE) begin
         if (col_ff != '0) begin
            col_sum = SUM_W'(col_ff) - SUM_W'(1);
         end else if (row_ff != '0) begin
            row_next = row_ff - ROW_W'(1);
            col_sum  = SUM_W'(eff_cols) - SUM_W'(1);
         end
      end else if (cp_ff == CH_TAB) begin
         col_sum  = (SUM_W'(col_ff) + SUM_W'(TAB_STOP)) & ~SUM_W'(TAB_STOP - 1);
         wrap_chk = 1'b1;
      end else begin
         printable = 1'b1;
         col_sum   = SUM_W'(col_ff) + SUM_W'(1);
         wrap_chk  = 1'b1;
      end
      if (wrap_chk && (col_sum >= SUM_W'(eff_cols))) begin
         col_sum  = '0;
         row_step = 1'b1;
      end
      // a scroll leaves the cursor on the bottom row, where it already is
      scroll_need = row_step && ((32'(row_ff) + 32'd1) >= 32'(eff_rows));
      if (row_step && !scroll_need) row_next = row_ff + ROW_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         scroll_cnt_ff <= '0;
      end else if (cmd.take) begin
         if (32'(row_ff) >= 32'(eff_rows)) row_ff <= ROW_W'(eff_rows - EROW_W'(1));
         if (32'(col_ff) >= 32'(eff_cols)) col_ff <= COL_W'(eff_cols - ECOL_W'(1));
      end else if (cmd.exec) begin
         row_ff        <= row_next;
         col_ff        <= COL_W'(col_sum);
         scroll_cnt_ff <= scroll_cnt_ff + SCROLL_W'(scroll_need);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         cp_ff    <= req_data.code_point;
         slot_ff  <= req_data.glyph_slot;
         total_ff <= CNT_W'(total_prod);
      end
      if (cmd.exec) begin
         res_ff.cursor_row   <= OUT_ROW_W'(row_next);
         res_ff.cursor_col   <= OUT_COL_W'(col_sum);
         res_ff.cell_written <= printable;
         res_ff.cell_index   <= printable ? OUT_IDX_W'(cell_addr) : '0;
         res_ff.cell_value   <= printable ? cell_val : '0;
         res_ff.scrolled     <= scroll_need;
         res_ff.scroll_total <= scroll_cnt_ff + SCROLL_W'(scroll_need);
      end
      if (cmd.publish) rsp_ff <= res_ff;
   end

   assign rsp_data = rsp_ff;

   // write port: clear sweep, cell store, scroll sweep
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      ra_wide   = '0;
      rd_ok_in  = rd_ok_ff;
      sweep_in  = sweep_ff;
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff[ADDR_W-1:0];
         mem_wdata = RESET_BLANK;
         sweep_in  = sweep_ff + CNT_W'(1);
      end
      if (cmd.exec && printable) begin
         mem_we    = 1'b1;
         mem_waddr = cell_addr;
         mem_wdata = cell_val;
      end
      if (cmd.scroll_prime) begin
         sweep_in  = '0;
         ra_wide   = RA_W'(eff_cols);
         rd_ok_in  = ra_wide < RA_W'(total_ff);
         mem_re    = rd_ok_in;
         mem_raddr = ra_wide[ADDR_W-1:0];
      end
      if (cmd.scroll_step) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff[ADDR_W-1:0];
         mem_wdata = rd_ok_ff ? rd_data_ff : blank_val;
         ra_wide   = RA_W'(sweep_ff) + RA_W'(1) + RA_W'(eff_cols);
         rd_ok_in  = ra_wide < RA_W'(total_ff);
         mem_re    = rd_ok_in;
         mem_raddr = ra_wide[ADDR_W-1:0];
         sweep_in  = sweep_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         rd_ok_ff <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= grid_mem[mem_raddr];
   end

   assign status.clear_last  = (sweep_ff == CNT_W'(CELLS - 1));
   assign status.scroll_need = scroll_need;
   assign status.scroll_last = (sweep_ff == (total_ff - CNT_W'(1)));

endmodule

/* hdl/text_console_cursor_grid.sv */
// Text console cursor grid: takes one decoded character word per handshake and keeps a
// grid of 16-bit cells (attribute in the high byte, glyph slot in the low byte) plus a
// cursor, returning one result word per character with the new cursor, the cell it wrote
// and the running scroll count. After reset the block sweeps all MAX_ROWS*MAX_COLUMNS
// cells of the store (10240 at the defaults) to blank cells, one cell a cycle;
// req_ready stays low until that pass ends, while register writes are taken at any time.
// An ordinary character or control is accepted, which clamps the cursor, then executed,
// which moves the cursor and stores the cell; the result then sits in an output register,
// and the next word is accepted in the same cycle the previous result is handed over. A
// scroll adds a priming step and a sweep over the rows*columns cells, through the single
// write port of the cell store: each cell is copied up one row through the registered read
// port, then the last row is written blank with the current attribute. The grid geometry
// and attribute registers must only be written while no word is in flight.
`include "text_console_cursor_grid_macros.svh"

module text_console_cursor_grid #(
   parameter int MAX_COLUMNS = tcg_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = tcg_pkg::DEF_MAX_ROWS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tcg_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tcg_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [tcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcg_pkg::CSR_DATA_W-1:0] csr_data
);
   import tcg_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: clear pass, accept, execute, scroll sweep, hand over
   tcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, cursor arithmetic, cell store and result registers
   tcg_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .cmd          (cmd),
      .status       (status)
   );

   // hold off input while the store is being cleared
   `TCG_ASSERT_SAME(a_no_accept_in_clear, cmd.clear_step, !req_ready, "word accepted during clear pass")

   // every accepted word is executed in the following cycle
   `TCG_ASSERT_NEXT(a_accept_then_exec, req_valid && req_ready, cmd.exec, "accepted word not executed")

   // no cell written means index and value read as zero
   `TCG_ASSERT_SAME(a_idle_cell_zero, rsp_valid && !rsp_data.cell_written, (rsp_data.cell_index == '0) && (rsp_data.cell_value == '0), "unwritten cell fields not zero")

   // a scrolled result never comes straight out of execute
   `TCG_ASSERT_NEXT(a_scroll_sweeps, cmd.exec && status.scroll_need, cmd.scroll_prime, "scroll skipped the grid sweep")

endmodule
